>>> sv/scfd_pkg.sv
// Package for the serial command frame display slave.
// Holds shared types, frame constants and the seven-segment lookup.
// No dependencies.
package scfd_pkg;

    localparam int          FRAME_BYTES = 9;
    localparam logic [3:0]  POS_LAST    = 4'd8;
    localparam logic [3:0]  POS_FIRST   = 4'd1;
    localparam logic [3:0]  POS_START   = 4'd0;

    localparam logic [7:0]  CMD_DISPLAY = 8'h30;
    localparam logic [7:0]  CMD_REPLY   = 8'h31;
    localparam logic [7:0]  CMD_SENSOR  = 8'h32;
    localparam logic [7:0]  ASCII_ZERO  = 8'h30;

    localparam logic [1:0]  CFG_UNIT_ADDR   = 2'd0;
    localparam logic [1:0]  CFG_HEADER_BYTE = 2'd1;
    localparam logic [1:0]  CFG_END_BYTE    = 2'd2;

    localparam logic [7:0]  RST_UNIT_ADDR   = 8'd57;
    localparam logic [7:0]  RST_HEADER_BYTE = 8'd126;
    localparam logic [7:0]  RST_END_BYTE    = 8'd127;

    localparam logic [3:0]  REP_HEADER = 4'd0;
    localparam logic [3:0]  REP_ID     = 4'd1;
    localparam logic [3:0]  REP_CMD    = 4'd2;
    localparam logic [3:0]  REP_SA     = 4'd6;
    localparam logic [3:0]  REP_SB     = 4'd7;
    localparam logic [3:0]  REP_END    = 4'd8;

    typedef struct packed {
        logic [7:0] unit_addr;
        logic [7:0] header_byte;
        logic [7:0] end_byte;
    } t_cfg;

    typedef struct packed {
        logic            valid;
        logic            is_reply;
        logic            sensor_a;
        logic            sensor_b;
        logic [4:0][7:0] segs;
    } t_event;

    function automatic logic [7:0] seg_of(input logic [7:0] c);
        logic [7:0] p;
        unique case (c)
            8'h30:   p = 8'hfc;
            8'h31:   p = 8'h60;
            8'h32:   p = 8'hda;
            8'h33:   p = 8'hf2;
            8'h34:   p = 8'h66;
            8'h35:   p = 8'hb6;
            8'h36:   p = 8'hbe;
            8'h37:   p = 8'he0;
            8'h38:   p = 8'hfe;
            8'h39:   p = 8'hf6;
            default: p = 8'h00;
        endcase
        return p;
    endfunction

endpackage

>>> sv/scfd_frame.sv
// Frame collector: tracks byte position, stores frame bytes and decodes
// a completed frame into a display or reply event.
// Depends on scfd_pkg.
module scfd_frame (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_sensor_a,
    input  logic              i_sensor_b,
    input  scfd_pkg::t_cfg    i_cfg,
    output logic              o_pos_last,
    output scfd_pkg::t_event  o_event
);

    logic [7:0] r_store [0:7];
    logic [3:0] r_pos;
    logic [3:0] n_pos;
    logic       complete;
    logic       match;

    always_comb begin
        if (r_pos == scfd_pkg::POS_START) begin
            n_pos = (i_rx_byte == i_cfg.header_byte) ? scfd_pkg::POS_FIRST
                                                     : scfd_pkg::POS_START;
        end else if (r_store[0] != i_cfg.header_byte) begin
            n_pos = scfd_pkg::POS_START;
        end else if (r_pos == scfd_pkg::POS_LAST) begin
            n_pos = scfd_pkg::POS_START;
        end else begin
            n_pos = r_pos + 4'd1;
        end
    end

    assign o_pos_last = (r_pos == scfd_pkg::POS_LAST);
    assign complete   = o_pos_last && (r_store[0] == i_cfg.header_byte);
    assign match      = (i_rx_byte == i_cfg.end_byte) && (r_store[1] == i_cfg.unit_addr);

    always_comb begin
        o_event.valid    = i_accept && complete && match &&
                           ((r_store[2] == scfd_pkg::CMD_DISPLAY) ||
                            (r_store[2] == scfd_pkg::CMD_SENSOR));
        o_event.is_reply = (r_store[2] == scfd_pkg::CMD_SENSOR);
        o_event.sensor_a = i_sensor_a;
        o_event.sensor_b = i_sensor_b;
        o_event.segs[0]  = scfd_pkg::seg_of(r_store[3]);
        o_event.segs[1]  = scfd_pkg::seg_of(r_store[4]);
        o_event.segs[2]  = scfd_pkg::seg_of(r_store[5]);
        o_event.segs[3]  = scfd_pkg::seg_of(r_store[6]);
        o_event.segs[4]  = scfd_pkg::seg_of(r_store[7]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= scfd_pkg::POS_START;
        end else if (i_accept) begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && !r_pos[3]) begin
            r_store[r_pos[2:0]] <= i_rx_byte;
        end
    end

endmodule

>>> sv/scfd_out.sv
// Result register and reply-frame sequencer.
// Loads display results directly and walks nine reply bytes one per transaction.
// Depends on scfd_pkg.
module scfd_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  scfd_pkg::t_event  i_event,
    input  scfd_pkg::t_cfg    i_cfg,
    input  logic              i_ready,
    output logic              o_valid,
    output logic              o_free,
    output logic              o_busy,
    output logic              o_kind,
    output logic [7:0]        o_tx_byte,
    output logic [4:0][7:0]   o_segs,
    output logic              o_last
);

    logic            r_valid;
    logic            r_kind;
    logic [7:0]      r_tx;
    logic [4:0][7:0] r_segs;
    logic            r_last;
    logic            r_busy;
    logic [3:0]      r_idx;
    logic            r_sa;
    logic            r_sb;
    logic [7:0]      rep_byte;

    always_comb begin
        unique case (r_idx)
            scfd_pkg::REP_HEADER: rep_byte = i_cfg.header_byte;
            scfd_pkg::REP_ID:     rep_byte = i_cfg.unit_addr;
            scfd_pkg::REP_CMD:    rep_byte = scfd_pkg::CMD_REPLY;
            scfd_pkg::REP_SA:     rep_byte = scfd_pkg::ASCII_ZERO | {7'd0, r_sa};
            scfd_pkg::REP_SB:     rep_byte = scfd_pkg::ASCII_ZERO | {7'd0, r_sb};
            scfd_pkg::REP_END:    rep_byte = i_cfg.end_byte;
            default:              rep_byte = scfd_pkg::ASCII_ZERO;
        endcase
    end

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_busy  <= 1'b0;
            r_idx   <= scfd_pkg::REP_HEADER;
        end else if (o_free) begin
            priority if (r_busy) begin
                r_valid <= 1'b1;
                r_kind  <= 1'b1;
                r_tx    <= rep_byte;
                r_segs  <= '0;
                r_last  <= (r_idx == scfd_pkg::REP_END);
                r_busy  <= (r_idx != scfd_pkg::REP_END);
                r_idx   <= r_idx + 4'd1;
            end else if (i_event.valid && i_event.is_reply) begin
                r_valid <= 1'b1;
                r_kind  <= 1'b1;
                r_tx    <= i_cfg.header_byte;
                r_segs  <= '0;
                r_last  <= 1'b0;
                r_busy  <= 1'b1;
                r_idx   <= scfd_pkg::REP_ID;
                r_sa    <= i_event.sensor_a;
                r_sb    <= i_event.sensor_b;
            end else if (i_event.valid) begin
                r_valid <= 1'b1;
                r_kind  <= 1'b0;
                r_tx    <= 8'd0;
                r_segs  <= i_event.segs;
                r_last  <= 1'b1;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid   = r_valid;
    assign o_busy    = r_busy;
    assign o_kind    = r_kind;
    assign o_tx_byte = r_tx;
    assign o_segs    = r_segs;
    assign o_last    = r_last;

endmodule

>>> sv/serial_command_frame_display_slave.sv
// Serial command frame display slave, top level.
// A frame-completing byte shows its first result in the cycle after acceptance.
// Throughput: one byte per cycle; a byte that completes a frame waits for a free
// result register, and a sensor reply holds off input until its last reply byte
// is in the result register.
// Reset: synchronous active-low i_rst_n; config registers go to defaults, position to 0.
module serial_command_frame_display_slave (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_sensor_a,
    input  logic       i_sensor_b,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_kind,
    output logic [7:0] o_tx_byte,
    output logic [7:0] o_seg_first,
    output logic [7:0] o_seg_second,
    output logic [7:0] o_seg_third,
    output logic [7:0] o_seg_fourth,
    output logic [7:0] o_seg_fifth,
    output logic       o_last
);

    scfd_pkg::t_cfg   r_cfg;
    scfd_pkg::t_event frame_event;
    logic             pos_last;
    logic             out_free;
    logic             out_busy;
    logic             accept;
    logic [4:0][7:0]  segs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.unit_addr   <= scfd_pkg::RST_UNIT_ADDR;
            r_cfg.header_byte <= scfd_pkg::RST_HEADER_BYTE;
            r_cfg.end_byte    <= scfd_pkg::RST_END_BYTE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                scfd_pkg::CFG_UNIT_ADDR:   r_cfg.unit_addr   <= i_cfg_data;
                scfd_pkg::CFG_HEADER_BYTE: r_cfg.header_byte <= i_cfg_data;
                scfd_pkg::CFG_END_BYTE:    r_cfg.end_byte    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_ready = !out_busy && (!pos_last || out_free);
    assign accept  = i_valid && o_ready;

    scfd_frame u_frame (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_rx_byte  (i_rx_byte),
        .i_sensor_a (i_sensor_a),
        .i_sensor_b (i_sensor_b),
        .i_cfg      (r_cfg),
        .o_pos_last (pos_last),
        .o_event    (frame_event)
    );

    scfd_out u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_event   (frame_event),
        .i_cfg     (r_cfg),
        .i_ready   (i_ready),
        .o_valid   (o_valid),
        .o_free    (out_free),
        .o_busy    (out_busy),
        .o_kind    (o_kind),
        .o_tx_byte (o_tx_byte),
        .o_segs    (segs),
        .o_last    (o_last)
    );

    assign o_seg_first  = segs[0];
    assign o_seg_second = segs[1];
    assign o_seg_third  = segs[2];
    assign o_seg_fourth = segs[3];
    assign o_seg_fifth  = segs[4];

endmodule

>>> sv/scfd_checker.sv
// Port-level checker for the serial command frame display slave.
// Bound to the top level; depends only on its ports.
module scfd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_kind,
    input logic [7:0] o_tx_byte,
    input logic [7:0] o_seg_first,
    input logic [7:0] o_seg_second,
    input logic [7:0] o_seg_third,
    input logic [7:0] o_seg_fourth,
    input logic [7:0] o_seg_fifth,
    input logic       o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    a_display_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_kind |-> o_last && (o_tx_byte == 8'd0))
        else $error("display result malformed");

    a_reply_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind |-> (o_seg_first == 8'd0) && (o_seg_second == 8'd0) &&
            (o_seg_third == 8'd0) && (o_seg_fourth == 8'd0) && (o_seg_fifth == 8'd0))
        else $error("reply byte carries segment data");

    a_reply_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_kind && !o_last |=> o_valid && o_kind)
        else $error("reply frame broken off");

    a_reply_stalls_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind && !o_last |-> !o_ready)
        else $error("input taken during reply frame");

endmodule

bind serial_command_frame_display_slave scfd_checker u_scfd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_kind       (o_kind),
    .o_tx_byte    (o_tx_byte),
    .o_seg_first  (o_seg_first),
    .o_seg_second (o_seg_second),
    .o_seg_third  (o_seg_third),
    .o_seg_fourth (o_seg_fourth),
    .o_seg_fifth  (o_seg_fifth),
    .o_last       (o_last)
);

>>> bench/tb_top.sv
// Testbench for serial_command_frame_display_slave: drives byte streams, writes
// registers between phases and checks each result against an in-bench predictor.
// Depends on scfd_pkg and the block's RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CFG_UNUSED   = 2'd3;
    localparam logic       KIND_DISPLAY = 1'b0;
    localparam logic       KIND_REPLY   = 1'b1;
    localparam int         POS_CMD      = 2;
    localparam int         POS_DATA     = 3;
    localparam int         IDLE_PCT     = 16;
    localparam int         STALL_LIMIT  = 3000;
    localparam int         DRAIN_CYCLES = 4;
    localparam int         REPORT_MAX   = 10;
    localparam int         PHASE_BYTES  = 24;
    localparam logic [9:0][7:0] DIGIT_SEG = {
        8'hf6, 8'hfe, 8'he0, 8'hbe, 8'hb6, 8'h66, 8'hf2, 8'hda, 8'h60, 8'hfc
    };

    typedef struct packed {
        logic            kind;
        logic [7:0]      tx;
        logic [4:0][7:0] seg;
        logic            last;
    } slave_resp_t;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [7:0] i_cfg_data;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_rx_byte;
    logic       i_sensor_a;
    logic       i_sensor_b;
    logic       o_valid;
    logic       i_ready;
    logic       o_kind;
    logic [7:0] o_tx_byte;
    logic [7:0] o_seg_first;
    logic [7:0] o_seg_second;
    logic [7:0] o_seg_third;
    logic [7:0] o_seg_fourth;
    logic [7:0] o_seg_fifth;
    logic       o_last;

    // predictor state
    logic [7:0]  cfg_dev;
    logic [7:0]  cfg_hdr;
    logic [7:0]  cfg_end;
    logic [3:0]  frame_pos;
    logic [7:0]  frame_buf [scfd_pkg::FRAME_BYTES];
    slave_resp_t resp_q [$];

    slave_resp_t seen_resp;
    slave_resp_t want_resp;
    int          fail_count;
    int          bytes_sent;
    int          display_seen;
    int          reply_seen;
    int          phases_run;
    int          quiet_cycles;
    int          hold_req;
    int          hold_left;
    bit          steady;

    serial_command_frame_display_slave dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_rx_byte    (i_rx_byte),
        .i_sensor_a   (i_sensor_a),
        .i_sensor_b   (i_sensor_b),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_kind       (o_kind),
        .o_tx_byte    (o_tx_byte),
        .o_seg_first  (o_seg_first),
        .o_seg_second (o_seg_second),
        .o_seg_third  (o_seg_third),
        .o_seg_fourth (o_seg_fourth),
        .o_seg_fifth  (o_seg_fifth),
        .o_last       (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(1));
    endfunction

    function automatic logic [7:0] digit_pattern(input logic [7:0] c);
        logic [7:0] d;
        d = c - scfd_pkg::ASCII_ZERO;
        return (d < 8'd10) ? DIGIT_SEG[d[3:0]] : 8'h00;
    endfunction

    function automatic void predict_rx(input logic [7:0] rx, input logic sa, input logic sb);
        slave_resp_t r;
        logic [7:0]  reply [scfd_pkg::FRAME_BYTES];
        frame_buf[frame_pos] = rx;
        frame_pos++;
        if (frame_buf[0] != cfg_hdr) frame_pos = scfd_pkg::POS_START;
        if (frame_pos < scfd_pkg::FRAME_BYTES) return;
        frame_pos = scfd_pkg::POS_START;
        if (frame_buf[scfd_pkg::POS_LAST] != cfg_end ||
            frame_buf[scfd_pkg::POS_FIRST] != cfg_dev) return;
        if (frame_buf[POS_CMD] == scfd_pkg::CMD_DISPLAY) begin
            r = '0;
            r.kind = KIND_DISPLAY;
            for (int k = 0; k < 5; k++) r.seg[k] = digit_pattern(frame_buf[POS_DATA + k]);
            r.last = 1'b1;
            resp_q.push_back(r);
        end else if (frame_buf[POS_CMD] == scfd_pkg::CMD_SENSOR) begin
            reply[0] = cfg_hdr;
            reply[1] = cfg_dev;
            reply[2] = scfd_pkg::CMD_REPLY;
            reply[3] = scfd_pkg::ASCII_ZERO;
            reply[4] = scfd_pkg::ASCII_ZERO;
            reply[5] = scfd_pkg::ASCII_ZERO;
            reply[6] = scfd_pkg::ASCII_ZERO | {7'd0, sa};
            reply[7] = scfd_pkg::ASCII_ZERO | {7'd0, sb};
            reply[8] = cfg_end;
            for (int k = 0; k < scfd_pkg::FRAME_BYTES; k++) begin
                r = '0;
                r.kind = KIND_REPLY;
                r.tx = reply[k];
                r.last = (k == scfd_pkg::FRAME_BYTES - 1);
                resp_q.push_back(r);
            end
        end
        for (int k = 0; k < scfd_pkg::FRAME_BYTES; k++) frame_buf[k] = 8'h00;
    endfunction

    task automatic note_failure(input string what, input slave_resp_t want,
                                input slave_resp_t got);
        fail_count++;
        if (fail_count <= REPORT_MAX) begin
            $display("%t %s: expected kind %0d tx %h seg %h %h %h %h %h last %0d",
                     $realtime, what, want.kind, want.tx, want.seg[0], want.seg[1],
                     want.seg[2], want.seg[3], want.seg[4], want.last);
            $display("%t %s:   actual kind %0d tx %h seg %h %h %h %h %h last %0d",
                     $realtime, what, got.kind, got.tx, got.seg[0], got.seg[1],
                     got.seg[2], got.seg[3], got.seg[4], got.last);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            seen_resp.kind   = o_kind;
            seen_resp.tx     = o_tx_byte;
            seen_resp.seg[0] = o_seg_first;
            seen_resp.seg[1] = o_seg_second;
            seen_resp.seg[2] = o_seg_third;
            seen_resp.seg[3] = o_seg_fourth;
            seen_resp.seg[4] = o_seg_fifth;
            seen_resp.last   = o_last;
            if (seen_resp.kind === KIND_REPLY) reply_seen++;
            else display_seen++;
            if (resp_q.size() == 0) begin
                note_failure("unexpected result", '0, seen_resp);
            end else begin
                want_resp = resp_q.pop_front();
                if (seen_resp.kind !== want_resp.kind || seen_resp.tx !== want_resp.tx ||
                    seen_resp.seg[0] !== want_resp.seg[0] ||
                    seen_resp.seg[1] !== want_resp.seg[1] ||
                    seen_resp.seg[2] !== want_resp.seg[2] ||
                    seen_resp.seg[3] !== want_resp.seg[3] ||
                    seen_resp.seg[4] !== want_resp.seg[4] ||
                    seen_resp.last !== want_resp.last) begin
                    note_failure("mismatch", want_resp, seen_resp);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: %0d cycles without a transaction", quiet_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result receiver: random stalls, optional long hold-off
    initial begin
        i_ready = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                i_ready = 1'b0;
                hold_left--;
            end else begin
                i_ready = steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    task automatic set_flow(input bit no_gaps, input int ready_hold);
        @(posedge i_clk);
        steady = no_gaps;
        hold_req = ready_hold;
        @(negedge i_clk);
    endtask

    // called at a falling edge; leaves valid high after the transaction
    task automatic send_byte(input logic [7:0] rx, input logic sa, input logic sb);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_rx_byte = rx;
        i_sensor_a = sa;
        i_sensor_b = sb;
        do @(posedge i_clk); while (!o_ready);
        predict_rx(rx, sa, sb);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_frame(input logic [7:0] dev, input logic [7:0] cmd,
                              input logic [4:0][7:0] digits, input logic [7:0] endb);
        send_byte(cfg_hdr, rand_bit(), rand_bit());
        send_byte(dev, rand_bit(), rand_bit());
        send_byte(cmd, rand_bit(), rand_bit());
        for (int k = 0; k < 5; k++) send_byte(digits[k], rand_bit(), rand_bit());
        send_byte(endb, rand_bit(), rand_bit());
    endtask

    task automatic wait_until_idle();
        i_valid = 1'b0;
        while (resp_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            scfd_pkg::CFG_UNIT_ADDR:   cfg_dev = value;
            scfd_pkg::CFG_HEADER_BYTE: cfg_hdr = value;
            scfd_pkg::CFG_END_BYTE:    cfg_end = value;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [7:0] dev, input logic [7:0] hdr,
                             input logic [7:0] endb);
        write_reg(scfd_pkg::CFG_UNIT_ADDR, dev);
        write_reg(scfd_pkg::CFG_HEADER_BYTE, hdr);
        write_reg(scfd_pkg::CFG_END_BYTE, endb);
        write_reg(CFG_UNUSED, rand_byte());
        phases_run++;
    endtask

    task automatic random_frame();
        int              pick;
        logic [7:0]      dev;
        logic [7:0]      cmd;
        logic [7:0]      endb;
        logic [4:0][7:0] digits;
        pick = $urandom_range(99);
        if (pick < 12) begin
            repeat ($urandom_range(1, 3))
                send_byte(rand_byte(), rand_bit(), rand_bit());
        end else if (pick < 20) begin
            // cut-short frame, later bytes fill it up
            send_byte(cfg_hdr, rand_bit(), rand_bit());
            repeat ($urandom_range(0, 4))
                send_byte(rand_byte(), rand_bit(), rand_bit());
        end else begin
            dev = ($urandom_range(99) < 8) ? rand_byte() : cfg_dev;
            endb = ($urandom_range(99) < 8) ? rand_byte() : cfg_end;
            pick = $urandom_range(99);
            if (pick < 42) cmd = scfd_pkg::CMD_DISPLAY;
            else if (pick < 84) cmd = scfd_pkg::CMD_SENSOR;
            else cmd = rand_byte();
            for (int k = 0; k < 5; k++) begin
                if ($urandom_range(99) < 85)
                    digits[k] = scfd_pkg::ASCII_ZERO + 8'($urandom_range(9));
                else digits[k] = rand_byte();
            end
            send_frame(dev, cmd, digits, endb);
        end
    endtask

    task automatic test_directed_frames();
        send_byte(8'hFF, 1'b1, 1'b1);
        send_byte(8'h00, 1'b0, 1'b0);
        // digit range edges and non-digits around them
        send_frame(cfg_dev, scfd_pkg::CMD_DISPLAY,
                   {8'hFF, 8'h3A, 8'h2F, scfd_pkg::ASCII_ZERO + 8'd9,
                    scfd_pkg::ASCII_ZERO}, cfg_end);
        send_frame(cfg_dev, scfd_pkg::CMD_SENSOR,
                   {scfd_pkg::ASCII_ZERO, scfd_pkg::ASCII_ZERO, scfd_pkg::ASCII_ZERO,
                    scfd_pkg::ASCII_ZERO, scfd_pkg::ASCII_ZERO}, cfg_end);
        wait_until_idle();
    endtask

    task automatic test_output_backpressure();
        set_flow(1'b1, 90);
        repeat (4)
            send_frame(cfg_dev, scfd_pkg::CMD_SENSOR,
                       {rand_byte(), rand_byte(), scfd_pkg::ASCII_ZERO,
                        scfd_pkg::ASCII_ZERO, rand_byte()}, cfg_end);
        wait_until_idle();
        set_flow(1'b0, 0);
    endtask

    task automatic test_random_phases();
        int start;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: configure(8'h00, 8'hFF, 8'h00);
                1: configure(8'hFF, 8'h00, 8'hFF);
                5: configure(scfd_pkg::RST_UNIT_ADDR, scfd_pkg::RST_HEADER_BYTE,
                             scfd_pkg::RST_END_BYTE);
                default: configure(rand_byte(), rand_byte(), rand_byte());
            endcase
            if (phase == 4) set_flow(1'b1, 0);
            start = bytes_sent;
            while (bytes_sent < start + PHASE_BYTES) random_frame();
            // leave a frame open across the next register change
            if ($urandom_range(1)) begin
                send_byte(cfg_hdr, rand_bit(), rand_bit());
                repeat ($urandom_range(0, 3))
                    send_byte(rand_byte(), rand_bit(), rand_bit());
            end
            wait_until_idle();
            if (phase == 4) set_flow(1'b0, 0);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = scfd_pkg::CFG_UNIT_ADDR;
        i_cfg_data = 8'h00;
        i_valid = 1'b0;
        i_rx_byte = 8'h00;
        i_sensor_a = 1'b0;
        i_sensor_b = 1'b0;
        cfg_dev = scfd_pkg::RST_UNIT_ADDR;
        cfg_hdr = scfd_pkg::RST_HEADER_BYTE;
        cfg_end = scfd_pkg::RST_END_BYTE;
        frame_pos = scfd_pkg::POS_START;
        for (int k = 0; k < scfd_pkg::FRAME_BYTES; k++) frame_buf[k] = 8'h00;
        fail_count = 0;
        bytes_sent = 0;
        display_seen = 0;
        reply_seen = 0;
        phases_run = 0;
        quiet_cycles = 0;
        hold_req = 0;
        steady = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_frames();
        test_output_backpressure();
        test_random_phases();
        wait_until_idle();

        $display("Sent %0d bytes under %0d register settings after the reset defaults",
                 bytes_sent, phases_run);
        $display("Checked %0d display updates and %0d reply bytes, %0d failures",
                 display_seen, reply_seen, fail_count);
        if (fail_count == 0 && resp_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/scfd_pkg.sv
sv/scfd_frame.sv
sv/scfd_out.sv
sv/serial_command_frame_display_slave.sv
sv/scfd_checker.sv
bench/tb_top.sv
